// ===== src/signed_int_to_radix_digits_unit_assert.svh =====
// Assertion macros for the signed integer to radix digits unit.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef SIGNED_INT_TO_RADIX_DIGITS_UNIT_ASSERT_SVH
`define SIGNED_INT_TO_RADIX_DIGITS_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SRD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/srd_pkg.sv =====
// Shared constants, divider request/response types and the digit character lookup
// for the signed integer to radix digits unit. No dependencies.
`default_nettype none

package srd_pkg;

	localparam int DATA_W      = 32;
	localparam int RADIX_W     = 5;
	localparam int DIGIT_W     = 4;
	localparam int CHAR_W      = 8;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int MAX_RADIX   = 16;
	localparam int MAX_DIGITS  = 32;
	localparam int PTR_W       = $clog2(MAX_DIGITS);
	localparam int CHUNK_W     = 8;
	localparam int DIV_STEPS   = DATA_W / CHUNK_W;
	localparam int CNT_W       = $clog2(DIV_STEPS);

	// Register indexes on the write port
	localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH = 2'd2;

	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

	typedef struct packed {
		logic                start;
		logic [DATA_W-1:0]   dividend;
		logic [RADIX_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [DATA_W-1:0]   quotient;
		logic [DIGIT_W-1:0]  remainder;
	} div_rsp_t;

	// Digit character at a position: 0..7 from the low word, 8..15 from the high word
	function automatic logic [CHAR_W-1:0] char_at(
		input logic [CFG_W-1:0]   chars_low,
		input logic [CFG_W-1:0]   chars_high,
		input logic [DIGIT_W-1:0] pos
	);
		logic [5:0] sel;
		sel = {pos[2:0], 3'b000};
		if (pos[3]) begin
			return chars_high[sel +: CHAR_W];
		end else begin
			return chars_low[sel +: CHAR_W];
		end
	endfunction

endpackage

`default_nettype wire

// ===== src/signed_int_to_radix_digits_unit.sv =====
// Top level of the signed integer to radix digits unit: configuration registers,
// sequencer, digit buffer and output register. Depends on srd_pkg, srd_alpha_check,
// srd_divider and signed_int_to_radix_digits_unit_assert.svh.
`default_nettype none
`include "signed_int_to_radix_digits_unit_assert.svh"

// Renders one signed 32-bit word per input as text in a configured radix (2 to 16),
// one character per output word, most significant digit first. A negative value
// gives a leading '-' and then the digits of its magnitude (the most negative value
// included); zero gives the single digit character 0; is_last marks the final
// character. If the alphabet is unusable (radix below 2 or above 16, a digit
// character that is NUL, '+' or '-', or two equal digit characters in use) the
// input word is consumed and nothing is produced. One input word is in flight at a
// time: in_stall stays high from acceptance until the last character has been
// loaded into the output register. A single divider produces the digits one after
// another, 8 quotient bits per cycle, and the characters are handed out once the
// division is done. Write configuration only while the unit is idle.
module signed_int_to_radix_digits_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration write port
	input  wire logic                           cfg_we,
	input  wire logic [srd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [srd_pkg::CFG_W-1:0]      cfg_data,
	// input channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic signed [srd_pkg::DATA_W-1:0] value,
	// output channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [srd_pkg::CHAR_W-1:0]          out_char,
	output logic                                is_last
);
	import srd_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CHECK = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_SIGN  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	// configuration registers
	logic [RADIX_W-1:0] radix_q;
	logic [CFG_W-1:0]   chars_lo_q;
	logic [CFG_W-1:0]   chars_hi_q;

	// sequencer and working storage
	state_t             state_q;
	state_t             state_d;
	logic [PTR_W-1:0]   ptr_q;
	logic [DIGIT_W-1:0] digits_q [MAX_DIGITS];
	logic [DATA_W-1:0]  mag_q;
	logic               neg_q;

	// output register
	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               is_last_q;

	logic               alpha_ok;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	logic [DATA_W-1:0]  raw;
	logic [DATA_W-1:0]  mag_in;
	logic               in_accept;
	logic               out_free;
	logic               out_load;
	logic               more_digits;
	logic [CHAR_W-1:0]  digit_char;

	srd_alpha_check u_alpha (
		.clk        (clk),
		.arst_n     (arst_n),
		.radix      (radix_q),
		.chars_low  (chars_lo_q),
		.chars_high (chars_hi_q),
		.ok         (alpha_ok)
	);

	srd_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Take the magnitude in unsigned arithmetic so the most negative value survives
	assign raw    = value;
	assign mag_in = raw[DATA_W-1] ? (~raw + DATA_W'(1)) : raw;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	// The output register can take a word when empty or when its word leaves now
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = out_free && (state_q == ST_SIGN || state_q == ST_EMIT);

	// Keep dividing while the quotient is nonzero and the buffer has room
	assign more_digits = (div_rsp.quotient != '0) && (ptr_q != PTR_W'(MAX_DIGITS - 1));

	// Kick the divider once the alphabet is known good, then chain on each digit
	assign div_req.start    = (state_q == ST_CHECK && alpha_ok)
		|| (state_q == ST_DIV && div_rsp.done && more_digits);
	assign div_req.dividend = (state_q == ST_CHECK) ? mag_q : div_rsp.quotient;
	assign div_req.divisor  = radix_q;

	assign digit_char = char_at(chars_lo_q, chars_hi_q, digits_q[ptr_q]);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				// drop the word silently on a bad alphabet
				state_d = alpha_ok ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				if (div_rsp.done && !more_digits) begin
					state_d = neg_q ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free && ptr_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration writes; index three is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q    <= '0;
			chars_lo_q <= '0;
			chars_hi_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RADIX:      radix_q    <= cfg_data[RADIX_W-1:0];
				REG_CHARS_LOW:  chars_lo_q <= cfg_data;
				REG_CHARS_HIGH: chars_hi_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer state, digit pointer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_accept) begin
				ptr_q <= '0;
			end else if (state_q == ST_DIV && div_rsp.done && more_digits) begin
				ptr_q <= ptr_q + PTR_W'(1);
			end else if (state_q == ST_EMIT && out_free && ptr_q != '0) begin
				ptr_q <= ptr_q - PTR_W'(1);
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: magnitude, sign, digit buffer (least significant first) and output word
	always_ff @(posedge clk) begin
		if (in_accept) begin
			mag_q <= mag_in;
			neg_q <= raw[DATA_W-1];
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			digits_q[ptr_q] <= div_rsp.remainder;
		end
		if (out_load) begin
			if (state_q == ST_SIGN) begin
				out_char_q <= CH_MINUS;
				is_last_q  <= 1'b0;
			end else begin
				out_char_q <= digit_char;
				is_last_q  <= (ptr_q == '0);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign is_last   = is_last_q;

	`SRD_ASSERT_IMP(a_div_start_free, div_req.start, !div_rsp.busy || div_rsp.done, "divider restarted mid-division")
	`SRD_ASSERT_IMP(a_rem_below_radix, div_rsp.done, RADIX_W'(div_rsp.remainder) < radix_q, "digit not below radix")
	`SRD_ASSERT_IMP(a_sign_only_neg, state_q == ST_SIGN, neg_q, "sign state for a nonnegative value")
	`SRD_ASSERT_NXT(a_last_to_idle, out_load && state_q == ST_EMIT && ptr_q == '0, state_q == ST_IDLE && is_last_q, "last digit did not close the word")

endmodule

`default_nettype wire

// ===== src/srd_alpha_check.sv =====
// Alphabet check: radix range, forbidden characters and duplicates, registered.
// Depends on srd_pkg.
`default_nettype none

module srd_alpha_check (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [srd_pkg::RADIX_W-1:0]  radix,
	input  wire logic [srd_pkg::CFG_W-1:0]    chars_low,
	input  wire logic [srd_pkg::CFG_W-1:0]    chars_high,
	output logic                              ok
);
	import srd_pkg::*;

	logic [CHAR_W-1:0]    ch [MAX_RADIX];
	logic [MAX_RADIX-1:0] used;
	logic                 bad;
	logic                 range_ok;
	logic                 ok_q;

	always_comb begin
		for (int a = 0; a < MAX_RADIX; a++) begin
			ch[a]   = char_at(chars_low, chars_high, DIGIT_W'(a));
			used[a] = RADIX_W'(a) < radix;
		end
	end

	// used[b] with b above a implies used[a]
	always_comb begin
		bad = 1'b0;
		for (int a = 0; a < MAX_RADIX; a++) begin
			if (used[a] && (ch[a] == CH_NUL || ch[a] == CH_MINUS || ch[a] == CH_PLUS)) begin
				bad = 1'b1;
			end
			for (int b = a + 1; b < MAX_RADIX; b++) begin
				if (used[b] && ch[a] == ch[b]) begin
					bad = 1'b1;
				end
			end
		end
	end

	assign range_ok = (radix >= RADIX_W'(2)) && (radix <= RADIX_W'(MAX_RADIX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
		end else begin
			ok_q <= range_ok && !bad;
		end
	end

	assign ok = ok_q;

endmodule

`default_nettype wire

// ===== src/srd_divider.sv =====
// Iterative divider: 32-bit dividend by a radix of up to 16,
// CHUNK_W quotient bits per cycle. Depends on srd_pkg.
`default_nettype none

module srd_divider (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire srd_pkg::div_req_t  req,
	output srd_pkg::div_rsp_t       rsp
);
	import srd_pkg::*;

	logic [DATA_W-1:0]  work_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;

	logic [DIGIT_W-1:0] step_rem;
	logic [RADIX_W-1:0] trial;
	logic [CHUNK_W-1:0] qbits;
	logic [DATA_W-1:0]  work_n;
	logic               last;

	// Restoring division over one chunk; remainder stays below the divisor
	always_comb begin
		step_rem = rem_q;
		trial    = '0;
		qbits    = '0;
		for (int i = 0; i < CHUNK_W; i++) begin
			trial = {step_rem, work_q[DATA_W-1-i]};
			if (trial >= req.divisor) begin
				step_rem             = DIGIT_W'(trial - req.divisor);
				qbits[CHUNK_W-1-i]   = 1'b1;
			end else begin
				step_rem = trial[DIGIT_W-1:0];
			end
		end
	end

	assign work_n = {work_q[DATA_W-CHUNK_W-1:0], qbits};
	assign last   = busy_q && (cnt_q == CNT_W'(DIV_STEPS - 1));

	assign rsp.busy      = busy_q;
	assign rsp.done      = last;
	assign rsp.quotient  = work_n;
	assign rsp.remainder = step_rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Dividend shifts out on top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= req.dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= work_n;
			rem_q  <= step_rem;
		end
	end

endmodule

`default_nettype wire
